// ===== sv/smtp_pkg.sv =====
// Shared types, constants and character codes for the square matrix text parser.
package smtp_pkg;

	localparam int MAX_SIZE_DEF = 16;
	localparam int CNT_W        = 7;
	localparam int IDX_W        = 6;
	localparam int MAG_W        = 32;

	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;

	typedef enum logic [2:0] {
		PH_OPEN     = 3'd0,
		PH_ROWSTART = 3'd1,
		PH_ELEM     = 3'd2,
		PH_NUM      = 3'd3,
		PH_SEP      = 3'd4,
		PH_DONE     = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_INT      = 3'd1,
		EV_LETTER   = 3'd2,
		EV_ACCEPTED = 3'd3,
		EV_REJECTED = 3'd4
	} event_t;

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} src_item_t;

	typedef struct packed {
		logic [2:0]         event_res;
		logic signed [31:0] int_value;
		logic [7:0]         letter;
		logic [IDX_W-1:0]   row_index;
		logic [IDX_W-1:0]   column_index;
		logic [CNT_W-1:0]   matrix_size;
	} res_item_t;

	typedef struct packed {
		phase_t           phase;
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             digit_seen;
		logic             space_seen;
		logic [CNT_W-1:0] elem_cnt;
		logic [CNT_W-1:0] row_cnt;
		logic [CNT_W-1:0] first_w;
		logic             failed;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		phase:      PH_OPEN,
		mag:        '0,
		neg:        1'b0,
		digit_seen: 1'b0,
		space_seen: 1'b0,
		elem_cnt:   '0,
		row_cnt:    '0,
		first_w:    '0,
		failed:     1'b0
	};

endpackage

// ===== sv/smtp_step.sv =====
// Next-state and result logic of the parser for one character item.
module smtp_step import smtp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  parse_state_t st,
	input  src_item_t    item,
	output parse_state_t nxt,
	output res_item_t    res
);

	logic [7:0]       ch;
	logic             is_ws;
	logic             is_letter;
	logic             is_digit;
	logic [MAG_W+3:0] mul_v;
	logic [MAG_W+3:0] lim_v;
	logic             ovf;
	logic             elem_full;
	logic             row_full;
	logic             accepted;

	assign ch        = item.character;
	assign is_ws     = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
	assign is_letter = ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) ||
	                   ((ch >= CH_LC_A) && (ch <= CH_LC_Z));
	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);

	// Times ten as two shifts and an add; the digit value is the low nibble.
	assign mul_v = ({4'b0, st.mag} << 3) + ({4'b0, st.mag} << 1) + (MAG_W+4)'(ch[3:0]);
	assign lim_v = st.neg ? (MAG_W+4)'(36'h080000000) : (MAG_W+4)'(36'h07FFFFFFF);
	assign ovf   = mul_v > lim_v;

	assign elem_full = st.elem_cnt >= CNT_W'(MAX_SIZE);
	assign row_full  = st.row_cnt >= CNT_W'(MAX_SIZE);
	assign accepted  = !st.failed && (st.phase == PH_DONE) && (st.row_cnt != '0) &&
	                   (st.row_cnt == st.first_w);

	// Handles the byte after an element: blanks, a comma or the row's closing bracket.
	function automatic parse_state_t sep_step(parse_state_t s, logic [7:0] c, logic ws);
		parse_state_t r;
		r = s;
		if (ws) begin
			r = s;
		end else if (c == CH_COMMA) begin
			r.phase = PH_ELEM;
		end else if (c == CH_CLOSE) begin
			if (s.row_cnt == '0) begin
				r.first_w    = s.elem_cnt;
				r.row_cnt    = s.row_cnt + 1'b1;
				r.space_seen = 1'b0;
				r.phase      = PH_ROWSTART;
			end else if (s.elem_cnt != s.first_w) begin
				r.failed = 1'b1;
			end else begin
				r.row_cnt    = s.row_cnt + 1'b1;
				r.space_seen = 1'b0;
				r.phase      = PH_ROWSTART;
			end
		end else begin
			r.failed = 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		nxt = st;
		if (item.end_of_text) begin
			nxt = PARSE_RESET;
		end else if (!st.failed) begin
			unique case (st.phase)
				PH_OPEN: begin
					if (ch == CH_OPEN) begin
						nxt.phase      = PH_ROWSTART;
						nxt.space_seen = 1'b0;
					end else if (!is_ws) begin
						nxt.failed = 1'b1;
					end
				end
				PH_ROWSTART: begin
					if ((ch == CH_CLOSE) && !st.space_seen) begin
						nxt.phase = PH_DONE;
					end else if (is_ws) begin
						nxt.space_seen = 1'b1;
					end else if (ch == CH_OPEN) begin
						if (row_full) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.elem_cnt = '0;
							nxt.phase    = PH_ELEM;
						end
					end else begin
						nxt.failed = 1'b1;
					end
				end
				PH_ELEM: begin
					if (is_letter) begin
						if (elem_full) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.elem_cnt = st.elem_cnt + 1'b1;
							nxt.phase    = PH_SEP;
						end
					end else begin
						nxt.mag        = '0;
						nxt.neg        = 1'b0;
						nxt.digit_seen = 1'b0;
						nxt.space_seen = 1'b0;
						nxt.phase      = PH_NUM;
						if (is_ws) begin
							nxt.space_seen = 1'b1;
						end else if (ch == CH_MINUS) begin
							nxt.neg = 1'b1;
						end else if (ch == CH_PLUS) begin
							nxt.neg = 1'b0;
						end else if (is_digit) begin
							// A first digit cannot overflow.
							nxt.mag        = MAG_W'(ch[3:0]);
							nxt.digit_seen = 1'b1;
						end else begin
							nxt.failed = 1'b1;
						end
					end
				end
				PH_NUM: begin
					if (is_digit) begin
						if (ovf) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.mag        = mul_v[MAG_W-1:0];
							nxt.digit_seen = 1'b1;
						end
					end else if (st.digit_seen) begin
						if (elem_full) begin
							nxt.failed = 1'b1;
						end else begin
							nxt.elem_cnt = st.elem_cnt + 1'b1;
							nxt.phase    = PH_SEP;
							nxt          = sep_step(nxt, ch, is_ws);
						end
					end else if (st.space_seen && is_ws) begin
						nxt.space_seen = 1'b1;
					end else if (st.space_seen && ((ch == CH_MINUS) || (ch == CH_PLUS))) begin
						nxt.neg        = (ch == CH_MINUS);
						nxt.space_seen = 1'b0;
					end else begin
						nxt.failed = 1'b1;
					end
				end
				PH_SEP: begin
					nxt = sep_step(st, ch, is_ws);
				end
				default: begin
					// Anything after the outer closing bracket is an error.
					nxt.failed = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		if (item.end_of_text) begin
			if (accepted) begin
				res.event_res   = EV_ACCEPTED;
				res.matrix_size = st.row_cnt;
			end else begin
				res.event_res = EV_REJECTED;
			end
		end else if (!st.failed && !elem_full) begin
			if ((st.phase == PH_ELEM) && is_letter) begin
				res.event_res    = EV_LETTER;
				res.letter       = ch;
				res.row_index    = st.row_cnt[IDX_W-1:0];
				res.column_index = st.elem_cnt[IDX_W-1:0];
			end else if ((st.phase == PH_NUM) && st.digit_seen && !is_digit) begin
				res.event_res    = EV_INT;
				res.int_value    = st.neg ? -$signed(st.mag) : $signed(st.mag);
				res.row_index    = st.row_cnt[IDX_W-1:0];
				res.column_index = st.elem_cnt[IDX_W-1:0];
			end
		end
	end

endmodule

// ===== sv/square_matrix_text_parser_core.sv =====
// Top level of the square matrix text parser: input register, parser state, result register.
//
// Usage: the source channel (src_valid, src_stall, src_item) carries one text byte per
// item, or an end-of-text marker. An item moves when valid is high and stall is low.
// Every accepted item yields exactly one result item on the result channel (res_valid,
// res_stall, res_item): an integer element, a letter element, an accepted or rejected
// verdict at end of text, or an empty event for bytes that finish nothing.
// Path: an accepted item is held in the input register, parsed from there and its result
// loaded into the result register once that is free; res_item then shows it.
// Throughput: one item per cycle unless res_stall holds. The parser state update for a byte
// is one short combinational step, so an item may follow every cycle while results drain.
// Stall: when the receiver stalls, the result register holds, the input register fills,
// and src_stall rises once both are occupied; nothing is lost or repeated.
// Reset: arst_n clears the valid flags and returns the parser to the state that expects
// the outer opening bracket. An end-of-text item also returns the parser to that state.
module square_matrix_text_parser_core import smtp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	output logic      src_stall,
	input  src_item_t src_item,
	output logic      res_valid,
	input  logic      res_stall,
	output res_item_t res_item
);

	// Input register stage.
	logic         vld_s1;
	src_item_t    item_s1;

	// Parser state and result register.
	parse_state_t state_q;
	parse_state_t state_nxt;
	res_item_t    res_nxt;
	res_item_t    res_q;
	logic         res_vld_q;

	logic         res_free;
	logic         advance;
	logic         take;

	// The result register can load when it is empty or being taken this cycle.
	assign res_free  = !res_vld_q || !res_stall;
	assign advance   = vld_s1 && res_free;
	assign src_stall = vld_s1 && !res_free;
	assign take      = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take || advance) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= src_item;
		end
	end

	smtp_step #(
		.MAX_SIZE(MAX_SIZE)
	) u_step (
		.st  (state_q),
		.item(item_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// The parser state only moves when the buffered item is handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (res_free) begin
			res_vld_q <= advance;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_vld_q;
	assign res_item  = res_q;

endmodule

// ===== sim/square_matrix_text_parser_core_checker.sv =====
// Watches both channels of the matrix text parser, predicts every result item and compares it.
`timescale 1ns / 1ps

module square_matrix_text_parser_core_checker import smtp_pkg::*; #(
	parameter int MAX_SIZE = MAX_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      src_valid,
	input  logic      src_stall,
	input  src_item_t src_item,
	input  logic      res_valid,
	input  logic      res_stall,
	input  res_item_t res_item,
	output int        fail_count,
	output int        pending,
	output int        int_elems,
	output int        letter_elems,
	output int        accepted,
	output int        rejected
);

	// Parser state as the predictor sees it.
	phase_t      cur_phase;
	logic [31:0] magnitude;
	logic        is_negative;
	logic        have_digit;
	logic        had_blank;
	logic [6:0]  col_cnt;
	logic [6:0]  row_cnt;
	logic [6:0]  row_width;
	logic        broken;

	res_item_t parser_events_q[$];
	int mismatches = 0;
	int n_int = 0;
	int n_letter = 0;
	int n_acc = 0;
	int n_rej = 0;

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
	endfunction

	task automatic clear_parser();
		cur_phase   = PH_OPEN;
		magnitude   = '0;
		is_negative = 1'b0;
		have_digit  = 1'b0;
		had_blank   = 1'b0;
		col_cnt     = '0;
		row_cnt     = '0;
		row_width   = '0;
		broken      = 1'b0;
	endtask

	// A row that is already full breaks the parse instead of emitting.
	task automatic emit_element(inout res_item_t ev, input event_t kind,
			input logic [31:0] value, input logic [7:0] code);
		if (col_cnt >= MAX_SIZE) begin
			broken = 1'b1;
		end else begin
			ev.event_res    = kind;
			ev.int_value    = value;
			ev.letter       = code;
			ev.row_index    = row_cnt[5:0];
			ev.column_index = col_cnt[5:0];
			col_cnt++;
		end
	endtask

	// Overflow is caught on the digit that leaves the signed 32-bit range.
	task automatic add_digit(input logic [7:0] c);
		logic [63:0] v;
		logic [63:0] lim;
		lim = is_negative ? 64'd2147483648 : 64'd2147483647;
		v = 64'(magnitude) * 64'd10 + 64'(c - CH_ZERO);
		if (v > lim) begin
			broken = 1'b1;
		end else begin
			magnitude  = v[31:0];
			have_digit = 1'b1;
		end
	endtask

	// Byte that follows a finished element: blank, comma or the row's closing bracket.
	task automatic after_element(input logic [7:0] c);
		if (is_blank(c)) begin
		end else if (c == CH_COMMA) begin
			cur_phase = PH_ELEM;
		end else if (c == CH_CLOSE) begin
			if (row_cnt == 0)
				row_width = col_cnt;
			else if (col_cnt != row_width)
				broken = 1'b1;
			if (!broken) begin
				row_cnt++;
				had_blank = 1'b0;
				cur_phase = PH_ROWSTART;
			end
		end else begin
			broken = 1'b1;
		end
	endtask

	task automatic step_parser(input src_item_t it, output res_item_t ev);
		logic [7:0] c;
		c = it.character;
		ev = '0;
		if (it.end_of_text) begin
			if (!broken && cur_phase == PH_DONE && row_cnt != 0 && row_cnt == row_width) begin
				ev.event_res   = EV_ACCEPTED;
				ev.matrix_size = row_cnt;
			end else begin
				ev.event_res = EV_REJECTED;
			end
			clear_parser();
		end else if (!broken) begin
			case (cur_phase)
				PH_OPEN: begin
					if (c == CH_OPEN) begin
						cur_phase = PH_ROWSTART;
						had_blank = 1'b0;
					end else if (!is_blank(c)) begin
						broken = 1'b1;
					end
				end
				PH_ROWSTART: begin
					if (c == CH_CLOSE && !had_blank) begin
						cur_phase = PH_DONE;
					end else if (is_blank(c)) begin
						had_blank = 1'b1;
					end else if (c == CH_OPEN) begin
						if (row_cnt >= MAX_SIZE) begin
							broken = 1'b1;
						end else begin
							col_cnt   = '0;
							cur_phase = PH_ELEM;
						end
					end else begin
						broken = 1'b1;
					end
				end
				PH_ELEM: begin
					if (is_letter(c)) begin
						emit_element(ev, EV_LETTER, 32'd0, c);
						if (!broken)
							cur_phase = PH_SEP;
					end else begin
						magnitude   = '0;
						is_negative = 1'b0;
						have_digit  = 1'b0;
						had_blank   = 1'b0;
						cur_phase   = PH_NUM;
						if (is_blank(c))
							had_blank = 1'b1;
						else if (c == CH_MINUS)
							is_negative = 1'b1;
						else if (is_digit(c))
							add_digit(c);
						else if (c != CH_PLUS)
							broken = 1'b1;
					end
				end
				PH_NUM: begin
					if (have_digit) begin
						if (is_digit(c)) begin
							add_digit(c);
						end else begin
							emit_element(ev, EV_INT,
								is_negative ? 32'd0 - magnitude : magnitude, 8'd0);
							if (!broken) begin
								cur_phase = PH_SEP;
								after_element(c);
							end
						end
					end else if (is_digit(c)) begin
						add_digit(c);
					end else if (had_blank && is_blank(c)) begin
					end else if (had_blank && (c == CH_MINUS || c == CH_PLUS)) begin
						is_negative = (c == CH_MINUS);
						had_blank   = 1'b0;
					end else begin
						broken = 1'b1;
					end
				end
				PH_SEP: after_element(c);
				default: broken = 1'b1;
			endcase
		end
	endtask

	function automatic int field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_item_t want;
		if (!arst_n) begin
			clear_parser();
			parser_events_q.delete();
		end else begin
			if (res_valid && !res_stall) begin
				if (parser_events_q.size() == 0) begin
					$error("result item arrived with nothing outstanding");
					mismatches++;
				end else begin
					want = parser_events_q.pop_front();
					mismatches += field_differs("event_res", 32'(want.event_res),
						32'(res_item.event_res));
					mismatches += field_differs("int_value", want.int_value,
						res_item.int_value);
					mismatches += field_differs("letter", 32'(want.letter),
						32'(res_item.letter));
					mismatches += field_differs("row_index", 32'(want.row_index),
						32'(res_item.row_index));
					mismatches += field_differs("column_index", 32'(want.column_index),
						32'(res_item.column_index));
					mismatches += field_differs("matrix_size", 32'(want.matrix_size),
						32'(res_item.matrix_size));
				end
			end
			if (src_valid && !src_stall) begin
				step_parser(src_item, want);
				parser_events_q.insert(parser_events_q.size(), want);
				case (want.event_res)
					EV_INT:      n_int++;
					EV_LETTER:   n_letter++;
					EV_ACCEPTED: n_acc++;
					EV_REJECTED: n_rej++;
					default: ;
				endcase
			end
		end
		fail_count   <= mismatches;
		pending      <= parser_events_q.size();
		int_elems    <= n_int;
		letter_elems <= n_letter;
		accepted     <= n_acc;
		rejected     <= n_rej;
	end

endmodule

// ===== sim/square_matrix_text_parser_core_tb.sv =====
// Testbench top for the square matrix text parser: text stimulus, flow control and verdict.
`timescale 1ns / 1ps

module square_matrix_text_parser_core_tb;
	import smtp_pkg::*;

	localparam int SIDE_MAX = MAX_SIZE_DEF;
	// Generous bound: about 1400 items, each with at most a long gap on the send
	// side and a long stall on the receive side, plus the one long hold.
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 80;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      src_valid = 1'b0;
	logic      src_stall;
	src_item_t src_item = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_item;

	int fail_count;
	int pending;
	int int_elems;
	int letter_elems;
	int accepted;
	int rejected;

	// Characters of the literal under construction, and the full item stream.
	logic [7:0] text_q[$];
	src_item_t  stim_q[$];
	int literals = 0;
	int items_sent = 0;
	int cycle_count = 0;
	bit holding = 1'b0;
	bit burst = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	square_matrix_text_parser_core #(
		.MAX_SIZE(SIDE_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item (res_item)
	);

	square_matrix_text_parser_core_checker #(
		.MAX_SIZE(SIDE_MAX)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_item    (src_item),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res_item    (res_item),
		.fail_count  (fail_count),
		.pending     (pending),
		.int_elems   (int_elems),
		.letter_elems(letter_elems),
		.accepted    (accepted),
		.rejected    (rejected)
	);

	// Length of an idle stretch, drawn from three ranges: mostly the shortest, now and then the longest.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 8);
		return $urandom_range(9, 30);
	endfunction

	// ---------------------------------------------------------------------
	// Text building. Each task appends bytes to the literal being assembled.
	// ---------------------------------------------------------------------
	task automatic put_char(input logic [7:0] c);
		text_q.insert(text_q.size(), c);
	endtask

	task automatic put_text(input string s);
		for (int k = 0; k < s.len(); k++)
			put_char(s[k]);
	endtask

	// Whitespace is any of the control codes from tab to carriage return, or space.
	task automatic put_blanks(input int most);
		int r;
		repeat ($urandom_range(0, most)) begin
			r = $urandom_range(0, 5);
			put_char(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
		end
	endtask

	task automatic put_letter();
		if ($urandom_range(0, 1))
			put_char(CH_UC_A + 8'($urandom_range(0, 25)));
		else
			put_char(CH_LC_A + 8'($urandom_range(0, 25)));
	endtask

	// Numbers lean on the interesting spots: single digits, both ends of the
	// 32-bit range, values just past it, and redundant leading zeros.
	task automatic put_number();
		longint unsigned mag;
		bit neg;
		string digits;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0, 1, 2: mag = 64'($urandom_range(0, 9));
			3, 4:    mag = 64'($urandom_range(10, 99999));
			5:       mag = 64'($urandom);
			6:       mag = neg ? 64'd2147483648 : 64'd2147483647;
			7:       mag = neg ? 64'd2147483649 : 64'd2147483648;
			8:       mag = {$urandom, $urandom} % 64'd100000000000;
			default: mag = 64'($urandom_range(0, 99));
		endcase
		if (neg)
			put_char(CH_MINUS);
		else if ($urandom_range(0, 3) == 0)
			put_char(CH_PLUS);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3)) put_char(CH_ZERO);
		digits = $sformatf("%0d", mag);
		put_text(digits);
	endtask

	// Builds a rows x cols literal. One row may be given a different width to
	// break the layout. With loose set, blanks go wherever the syntax allows them.
	task automatic make_matrix(input int rows, input int cols, input int odd_row,
			input int odd_width, input bit loose, input int letter_pct);
		int row;
		int col;
		int w;
		if (loose)
			put_blanks(2);
		put_char(CH_OPEN);
		if (loose)
			put_blanks(2);
		for (row = 0; row < rows; row++) begin
			w = (row == odd_row) ? odd_width : cols;
			put_char(CH_OPEN);
			for (col = 0; col < w; col++) begin
				if (col > 0)
					put_char(CH_COMMA);
				if ($urandom_range(1, 100) <= letter_pct) begin
					put_letter();
				end else begin
					if (loose)
						put_blanks(2);
					put_number();
				end
				if (loose)
					put_blanks(1);
			end
			put_char(CH_CLOSE);
			// A blank before the outer closing bracket is illegal, so none after the last row.
			if (loose && row < rows - 1)
				put_blanks(2);
		end
		put_char(CH_CLOSE);
	endtask

	// Damages a well-formed literal in one of the ways the grammar rejects
	// (or, for a random byte, may happen to accept).
	task automatic damage_text();
		int pos;
		int k;
		pos = $urandom_range(0, text_q.size() - 1);
		case ($urandom_range(0, 5))
			0: while (text_q.size() > pos) void'(text_q.pop_back());
			1: text_q.insert(pos, 8'($urandom));
			2: text_q[pos] = 8'($urandom);
			3: text_q.insert(text_q.size(), $urandom_range(0, 1) ? CH_SPACE : 8'($urandom));
			4: text_q.insert(text_q.size() - 1, CH_SPACE);
			default: begin
				// A blank in front of a letter element.
				pos = text_q.size() - 1;
				for (k = text_q.size() - 1; k >= 0; k--)
					if ((text_q[k] >= CH_UC_A && text_q[k] <= CH_UC_Z) ||
							(text_q[k] >= CH_LC_A && text_q[k] <= CH_LC_Z))
						pos = k;
				text_q.insert(pos, CH_TAB);
			end
		endcase
	endtask

	// Flushes the assembled text into the item stream, closed by an end-of-text item.
	task automatic close_literal();
		foreach (text_q[k])
			stim_q.insert(stim_q.size(),
				src_item_t'{character: text_q[k], end_of_text: 1'b0});
		stim_q.insert(stim_q.size(),
			src_item_t'{character: 8'($urandom), end_of_text: 1'b1});
		text_q.delete();
		literals++;
	endtask

	task automatic random_literal();
		string alphabet;
		int r;
		int n;
		bit loose;
		alphabet = "[[]],,+-0919aZ \t\r";
		r = $urandom_range(0, 99);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
		loose = 1'($urandom_range(0, 1));
		if (r < 50) begin
			make_matrix(n, n, -1, 0, loose, 40);
		end else if (r < 60) begin
			if ($urandom_range(0, 1))
				make_matrix(n, n + $urandom_range(1, 2), -1, 0, loose, 40);
			else
				make_matrix(n + 1, n + 1, $urandom_range(0, n), $urandom_range(0, n + 2),
					loose, 40);
		end else if (r < 75) begin
			make_matrix(n, n, -1, 0, loose, 40);
			damage_text();
		end else if (r < 78) begin
			// One element too many in a row.
			make_matrix(1, SIDE_MAX + 1, -1, 0, 1'b0, 100);
		end else if (r < 81) begin
			// One row too many.
			make_matrix(SIDE_MAX + 1, 1, -1, 0, 1'b0, 100);
		end else if (r < 92) begin
			repeat ($urandom_range(0, 24))
				put_char(alphabet[$urandom_range(0, alphabet.len() - 1)]);
		end else begin
			repeat ($urandom_range(0, 16))
				put_char(8'($urandom));
		end
		close_literal();
	endtask

	// ---------------------------------------------------------------------
	// Source side. Gaps are skipped during a burst and during the long
	// receiver hold, so the block is kept under load there.
	// ---------------------------------------------------------------------
	task automatic offer_item(input src_item_t it);
		int gap;
		gap = (holding || burst || $urandom_range(0, 99) < 60) ? 0 : idle_len();
		if (gap > 0) begin
			src_valid <= 1'b0;
			src_item  <= '{character: 8'($urandom), end_of_text: 1'($urandom)};
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Result side: stretches of flow and stall, each stall followed by flow, with one long hold
	// early in the run that lets the block fill up and push back on its input.
	initial begin : receiver
		int run;
		bit stalling;
		bit held;
		run = 0;
		stalling = 1'b0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && items_sent >= 300) begin
				held = 1'b1;
				holding = 1'b1;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				holding = 1'b0;
			end
			if (run == 0) begin
				stalling = !stalling && $urandom_range(0, 1);
				if (stalling)
					run = idle_len();
				else
					run = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 200 : 20);
			end
			run--;
			res_stall <= stalling;
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin : main
		src_item_t it;

		// Directed opening: the empty matrix, the smallest letter matrix and the
		// most negative integer, each closed by end of text.
		put_text("[]");
		close_literal();
		put_text("[[z]]");
		close_literal();
		put_text("[[-2147483648]]");
		close_literal();

		// The largest matrix that can be accepted, then random literals.
		make_matrix(SIDE_MAX, SIDE_MAX, -1, 0, 1'b0, 100);
		close_literal();
		while (stim_q.size() < 1400)
			random_literal();

		// Reset once, then released.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (stim_q.size() > 0) begin
			it = stim_q.pop_front();
			offer_item(it);
			// A new burst setting for each literal, so some run without any gaps.
			if (it.end_of_text)
				burst = ($urandom_range(0, 3) == 0);
		end
		src_valid <= 1'b0;

		// Drain: the outstanding count is registered in the checker, so wait for a clock edge first.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);

		$display("Sent %0d items in %0d literals over %0d cycles.",
			items_sent, literals, cycle_count);
		$display("Saw %0d integer and %0d letter elements, %0d matrices accepted, %0d rejected.",
			int_elems, letter_elems, accepted, rejected);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
